[rtl/wls_pkg.sv]
// Shared constants, types and result codes for the weighted lottery selector.
package wls_pkg;

    // Number of weight registers and visited bits held by the block.
    localparam int SLOT_COUNT  = 8;
    // Number of entries that take part in the draw (2 to SLOT_COUNT).
    localparam int NUM_ENTRIES = 8;
    // Weight bits that count towards the draw (4 to 32).
    localparam int WEIGHT_BITS = 16;
    // Fraction width of the random value (8 to 32).
    localparam int RANDOM_BITS = 16;

    // Fixed widths of the register file and the stream fields.
    localparam int CFG_W    = 16;
    localparam int RND_W    = 16;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Widths that follow from the constants above.
    localparam int W_USED  = (WEIGHT_BITS < CFG_W) ? WEIGHT_BITS : CFG_W;
    localparam int R_USED  = (RANDOM_BITS < RND_W) ? RANDOM_BITS : RND_W;
    localparam int TOTAL_W = W_USED + IDX_W;
    localparam int PROD_W  = R_USED + TOTAL_W;

    typedef logic [CFG_W-1:0] weight_t;
    typedef logic [SLOT_COUNT-1:0][CFG_W-1:0] weight_bank_t;
    typedef logic [SLOT_COUNT-1:0] slot_mask_t;

    // Result kinds carried on the result channel.
    typedef enum logic [1:0] {
        OUTCOME_CHOSEN    = 2'd0,
        OUTCOME_SUCCESS   = 2'd1,
        OUTCOME_EXHAUSTED = 2'd2
    } outcome_t;

    // One draw: the reported result and the visited mask it leaves behind.
    typedef struct packed {
        outcome_t            outcome;
        logic [IDX_W-1:0]    entry;
        slot_mask_t          mask;
    } pick_t;

endpackage

[rtl/weighted_lottery_selector.sv]
// Top level of the weighted lottery selector: register file, stream stages and draw.
//
// Draws one of up to eight weighted entries without replacement. Each request
// beat on the s_ channel carries random_value in s_tdata and child_succeeded in
// s_tuser. A successful child clears the visited mask and reports success;
// otherwise the entry whose interval holds the scaled random value is reported
// and marked visited, and an empty pool clears the mask and reports failure.
// The result beat on the m_ channel carries chosen_entry in m_tdata and the
// outcome in m_tuser.
// Weights are written through the APB port at byte address 4*i, one per entry,
// and must only be changed while no request is in flight.
// A request beat passes through one input register and one result register,
// with the prefix sum, multiply and search between.
// Throughput is one beat per cycle while the receiver takes every result beat;
// the visited mask is updated on the same edge as the result register, so the next request sees it at once.
// Reset sets every weight to 1, clears the visited mask and empties both stages.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then falls until the result beat is taken.
module weighted_lottery_selector (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wls_pkg::ADDR_W-1:0]  paddr,
    input  logic [wls_pkg::DATA_W-1:0]  pwdata,
    output logic [wls_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] random_value
    input  logic                        s_tuser,   // [0] child_succeeded
    // Result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [2:0] chosen_entry, [7:3] zero
    output logic [1:0]                  m_tuser    // [1:0] outcome
);
    import wls_pkg::*;

    weight_bank_t       weights_reg;
    slot_mask_t         mask_reg;
    logic               in_vld_reg;
    logic               in_succ_reg;
    logic [RND_W-1:0]   in_rnd_reg;
    logic               out_vld_reg;
    outcome_t           out_outcome_reg;
    logic [IDX_W-1:0]   out_entry_reg;
    logic [IDX_W-1:0]   reg_idx;
    logic               cfg_write;
    logic               advance;
    logic               in_vld_next;
    logic               out_vld_next;
    pick_t              pick;

    // Register file access.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = DATA_W'(weights_reg[reg_idx]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                weights_reg[i] <= weight_t'(1);
            end
        end else if (cfg_write) begin
            weights_reg[reg_idx] <= pwdata[CFG_W-1:0];
        end
    end

    // Stage handshake: the draw moves on whenever the result register is free.
    assign advance      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready     = !in_vld_reg || advance;
    assign in_vld_next  = (s_tvalid && s_tready) || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mask_reg    <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                mask_reg <= pick.mask;
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_succ_reg <= s_tuser;
            in_rnd_reg  <= s_tdata;
        end
    end

    // The draw itself.
    wls_select u_select (
        .weights      (weights_reg),
        .mask         (mask_reg),
        .succeeded    (in_succ_reg),
        .random_value (in_rnd_reg),
        .pick         (pick)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_outcome_reg <= pick.outcome;
            out_entry_reg   <= pick.entry;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 8'(out_entry_reg);
    assign m_tuser  = out_outcome_reg;

endmodule

[rtl/wls_select.sv]
// Combinational draw: masked prefix sums, random scaling and interval search.
module wls_select (
    input  wls_pkg::weight_bank_t weights,
    input  wls_pkg::slot_mask_t   mask,
    input  logic                  succeeded,
    input  logic [wls_pkg::RND_W-1:0] random_value,
    output wls_pkg::pick_t        pick
);
    import wls_pkg::*;

    logic [TOTAL_W-1:0] cum [SLOT_COUNT];
    logic [TOTAL_W-1:0] total;
    logic [PROD_W-1:0]  prod;
    logic [TOTAL_W-1:0] r;
    logic [IDX_W-1:0]   sel;
    logic               found;

    // Running sum of the weights of unvisited active entries, in index order.
    always_comb begin
        logic [TOTAL_W-1:0] run;
        logic [TOTAL_W-1:0] w;
        run = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i < NUM_ENTRIES && !mask[i]) begin
                w = TOTAL_W'(weights[i][W_USED-1:0]);
            end else begin
                w = '0;
            end
            run    = run + w;
            cum[i] = run;
        end
        total = run;
    end

    // Scale the random fraction onto the total weight.
    assign prod = PROD_W'(random_value[R_USED-1:0]) * PROD_W'(total);
    assign r    = TOTAL_W'(prod >> RANDOM_BITS);

    // The first entry whose cumulative sum passes r owns the interval holding r.
    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (cum[i] > r) begin
                sel   = IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    // Pick the result and the mask that the draw leaves behind.
    always_comb begin
        pick.outcome = OUTCOME_EXHAUSTED;
        pick.entry   = '0;
        pick.mask    = '0;
        if (succeeded) begin
            pick.outcome = OUTCOME_SUCCESS;
        end else if (total != '0 && found) begin
            pick.outcome   = OUTCOME_CHOSEN;
            pick.entry     = sel;
            pick.mask      = mask;
            pick.mask[sel] = 1'b1;
        end
    end

endmodule

[bench/weighted_lottery_selector_tb.sv]
// Self-checking testbench for the weighted lottery selector with a predicting scoreboard.
module weighted_lottery_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wls_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_SETS = 8;
    localparam int ITEMS_PER_SET = 100;

    // One expected result beat.
    typedef struct {
        outcome_t         outcome;
        logic [IDX_W-1:0] entry;
    } draw_t;

    // Tracks the weights and the visited mask, predicts each draw and checks result beats.
    class lottery_ledger;
        logic [CFG_W-1:0]      weight_reg [SLOT_COUNT];
        logic [SLOT_COUNT-1:0] visited;
        draw_t                 pending_draws [$];
        int                    mismatches;

        function new();
            foreach (weight_reg[i]) weight_reg[i] = 16'd1;
            visited = '0;
            mismatches = 0;
        endfunction

        function void set_weight(int idx, logic [CFG_W-1:0] value);
            weight_reg[idx] = value;
        endfunction

        function int outstanding();
            return pending_draws.size();
        endfunction

        // Works out the result of one request and advances the visited mask.
        function draw_t draw_next(logic succeeded, logic [RND_W-1:0] rnd);
            draw_t      d;
            logic [63:0] wmask;
            logic [63:0] rmask;
            logic [63:0] total;
            logic [63:0] r;
            logic [63:0] start;
            logic [63:0] w;
            wmask = (64'd1 << WEIGHT_BITS) - 64'd1;
            rmask = (64'd1 << RANDOM_BITS) - 64'd1;
            d.outcome = OUTCOME_CHOSEN;
            d.entry = '0;
            if (succeeded) begin
                visited = '0;
                d.outcome = OUTCOME_SUCCESS;
                return d;
            end
            total = 64'd0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (!visited[i]) total += 64'(weight_reg[i]) & wmask;
            end
            // An empty pool starts a fresh round and reports exhaustion.
            if (total == 64'd0) begin
                visited = '0;
                d.outcome = OUTCOME_EXHAUSTED;
                return d;
            end
            r = ((64'(rnd) & rmask) * total) >> RANDOM_BITS;
            start = 64'd0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (!visited[i]) begin
                    w = 64'(weight_reg[i]) & wmask;
                    if (r >= start && r < start + w) begin
                        visited[i] = 1'b1;
                        d.entry = IDX_W'(i);
                        return d;
                    end
                    start += w;
                end
            end
            visited = '0;
            d.outcome = OUTCOME_EXHAUSTED;
            return d;
        endfunction

        function void note_request(logic succeeded, logic [RND_W-1:0] rnd);
            pending_draws.push_back(draw_next(succeeded, rnd));
        endfunction

        function void check_result(logic [7:0] data, logic [1:0] kind);
            draw_t want;
            if (pending_draws.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing outstanding: tuser=%0d tdata=%h",
                             kind, data);
                return;
            end
            want = pending_draws.pop_front();
            if (kind !== want.outcome || data !== {5'b0, want.entry}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("draw mismatch: expected %s entry %0d, got tuser=%0d tdata=%h",
                             want.outcome.name(), want.entry, kind, data);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;   // [15:0] random_value
    logic              s_tuser = 1'b0; // [0] child_succeeded
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;        // [2:0] chosen_entry, [7:3] zero
    logic [1:0]        m_tuser;        // [1:0] outcome

    lottery_ledger     ledger;
    int                send_idle_pct = 33;
    int                recv_idle_pct = 88;
    int                quiet_cycles = 0;
    logic [CFG_W-1:0]  next_weights [SLOT_COUNT];

    weighted_lottery_selector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Result side: check every accepted beat and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: give up when no beat has moved on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL weighted_lottery_selector");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly ordinary random values, with the two extremes now and then.
    function logic [15:0] pick_random();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Offers one request beat, after a random gap, and waits until it is taken.
    task send_req(input logic succeeded, input logic [15:0] rnd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rnd;
        s_tuser <= succeeded;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        ledger.note_request(succeeded, rnd);
    endtask

    // Stops requests and waits until every result is back and the pipeline is empty.
    task drain();
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all weight registers from next_weights, each with a setup phase and an access phase.
    task write_bank();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= ADDR_W'(4 * i);
            pwdata <= DATA_W'(next_weights[i]);
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            ledger.set_weight(i, next_weights[i]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Weight patterns for the random sets: extremes, sparse pools and ordinary mixes.
    task fill_weights(input int set_no);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            case (set_no)
                0: next_weights[i] = 16'hFFFF;
                2: begin
                    case ($urandom_range(3))
                        0: next_weights[i] = 16'h0000;
                        1: next_weights[i] = 16'h0001;
                        2: next_weights[i] = 16'hFFFF;
                        default: next_weights[i] = 16'($urandom_range(65535));
                    endcase
                end
                3, 6: next_weights[i] = 16'h0000;
                4: next_weights[i] = 16'($urandom_range(3));
                default: next_weights[i] = 16'($urandom_range(65535));
            endcase
        end
        // A single live entry, or only the top two live.
        if (set_no == 3) begin
            next_weights[$urandom_range(SLOT_COUNT - 1)] = 16'($urandom_range(1, 65535));
        end
        if (set_no == 6) begin
            next_weights[6] = 16'hFFFF;
            next_weights[7] = 16'h0001;
        end
    endtask

    // Mostly whole rounds of failed draws closed by a success, the rest loose beats.
    task run_random(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(9);
                repeat (len) begin
                    send_req(1'b0, pick_random());
                    sent++;
                end
                send_req(1'b1, pick_random());
                sent++;
            end else begin
                send_req(1'($urandom_range(1)), pick_random());
                sent++;
            end
        end
    endtask

    initial begin
        ledger = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset weights: lowest and highest random values, then exhaust the pool.
        send_req(1'b0, 16'h0000);
        send_req(1'b0, 16'hFFFF);
        repeat (6) send_req(1'b0, 16'h8000);
        send_req(1'b0, 16'h1234);
        send_req(1'b1, 16'hFFFF);
        send_req(1'b1, 16'h0000);
        send_req(1'b0, 16'hFFFF);

        // Every weight at its maximum.
        drain();
        foreach (next_weights[i]) next_weights[i] = 16'hFFFF;
        write_bank();
        send_req(1'b0, 16'hFFFF);
        send_req(1'b0, 16'h0000);
        send_req(1'b1, 16'h5A5A);

        // Every weight zero: the pool is empty straight away.
        drain();
        foreach (next_weights[i]) next_weights[i] = 16'h0000;
        write_bank();
        send_req(1'b0, 16'hFFFF);
        send_req(1'b1, 16'hA5A5);

        // Zero-weight entries in between must be skipped.
        drain();
        foreach (next_weights[i]) next_weights[i] = 16'h0000;
        next_weights[0] = 16'h0001;
        next_weights[7] = 16'hFFFF;
        write_bank();
        send_req(1'b0, 16'h0000);
        send_req(1'b0, 16'hFFFF);
        send_req(1'b0, 16'h0005);

        // Random sets under the three flow-control regimes.
        for (int k = 0; k < RANDOM_SETS; k++) begin
            drain();
            if (k < 3) begin
                send_idle_pct = 33;
                recv_idle_pct = 88;
            end else if (k < 6) begin
                send_idle_pct = 88;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            fill_weights(k);
            write_bank();
            run_random(ITEMS_PER_SET);
        end

        drain();
        if (ledger.mismatches == 0) begin
            $display("PASS weighted_lottery_selector");
        end else begin
            $display("FAIL weighted_lottery_selector");
        end
        $finish;
    end

endmodule

[weighted_lottery_selector.f]
rtl/wls_pkg.sv
rtl/wls_select.sv
rtl/weighted_lottery_selector.sv
bench/weighted_lottery_selector_tb.sv
